// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Combinational implication checked at every edge outside reset.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequence must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/tra_pkg.sv
// ----------------------------------------------------------------------------
// tra_pkg
// Shared types, opcodes and sizes of the two-register accumulator machine.
// ----------------------------------------------------------------------------
package tra_pkg;

	localparam int STORE_DEPTH = 16;
	localparam int PC_BITS     = 8;

	localparam int ACT_W  = 4;
	localparam int ADDR_W = 4;
	localparam int WORD_W = 32;
	localparam int TGT_W  = 8;
	localparam int PCO_W  = 8;

	localparam int IDX_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int ADDR_SPAN  = 1 << ADDR_W;
	localparam int MOD_STEPS  = (ADDR_SPAN - 1) / STORE_DEPTH;

	localparam int IN_FIELDS_W  = ACT_W + ADDR_W + WORD_W + TGT_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = PCO_W + WORD_W + WORD_W + 2;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [ACT_W-1:0] OP_DEC = 4'd0;
	localparam logic [ACT_W-1:0] OP_LDA = 4'd1;
	localparam logic [ACT_W-1:0] OP_LDB = 4'd2;
	localparam logic [ACT_W-1:0] OP_LDI = 4'd3;
	localparam logic [ACT_W-1:0] OP_ST  = 4'd4;
	localparam logic [ACT_W-1:0] OP_XCH = 4'd5;
	localparam logic [ACT_W-1:0] OP_JMP = 4'd6;
	localparam logic [ACT_W-1:0] OP_JZS = 4'd7;
	localparam logic [ACT_W-1:0] OP_JVS = 4'd8;
	localparam logic [ACT_W-1:0] OP_ADD = 4'd9;
	localparam logic [ACT_W-1:0] OP_HLT = 4'd10;

	typedef struct packed {
		logic [TGT_W-1:0]         jump_target;
		logic signed [WORD_W-1:0] immediate;
		logic [ADDR_W-1:0]        mem_address;
		logic [ACT_W-1:0]         action;
	} instr_t;

	typedef struct packed {
		logic [PC_BITS-1:0]       pc;
		logic signed [WORD_W-1:0] a;
		logic signed [WORD_W-1:0] b;
		logic                     zf;
		logic                     vf;
	} arch_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] data;
	} store_wr_t;

	// Fold a store address into the store depth by repeated subtraction.
	function automatic logic [IDX_W-1:0] word_index(input logic [ADDR_W-1:0] addr);
		logic [ADDR_W-1:0] v;
		v = addr;
		for (int i = 0; i < MOD_STEPS; i++) begin
			if (int'(v) >= STORE_DEPTH) begin
				v = v - ADDR_W'(STORE_DEPTH);
			end
		end
		return IDX_W'(v);
	endfunction

endpackage

// File: rtl/two_register_accumulator_cpu.sv
// ----------------------------------------------------------------------------
// two_register_accumulator_cpu
// Accumulator machine executing one decoded instruction per transaction.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Fields (tdata, low bit first)
// s_*      in   action[3:0] mem_address[7:4] immediate[39:8] jump_target[47:40]
// m_*      out  pc_out[7:0] acc_a[39:8] acc_b[71:40] zero_bit[72] ovf_bit[73]
//
// One instruction per cycle while the result channel accepts; the input register
// feeds the execute logic, which loads the result register.
// Reset clears A, B, PC, both flags and every store valid bit, so the store
// reads zero right after reset with no clearing pass.
// A stalled result holds in the result register; one instruction waits in the
// input register and s_tready drops until the result moves on.
//
`include "assert_macros.svh"

module two_register_accumulator_cpu import tra_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// action, mem_address, immediate, jump_target
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// pc_out, acc_a, acc_b, zero_bit, ovf_bit, zero padding
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic                   valid_s1;
	instr_t                 instr_s1;
	logic                   exec;
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [WORD_W-1:0]      rd_data;
	logic [IDX_W-1:0]       rd_idx;
	store_wr_t              wr;
	arch_t                  nxt;

	// Execute when an instruction waits and the result register is free or draining.
	assign exec     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || exec;

	// Input register: capture a transaction, drop it once executed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			instr_s1 <= instr_t'(s_tdata[IN_FIELDS_W-1:0]);
		end
	end

	tra_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	tra_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.exec    (exec),
		.instr   (instr_s1),
		.rd_data (rd_data),
		.rd_idx  (rd_idx),
		.wr      (wr),
		.nxt     (nxt)
	);

	// Result register: hold while stalled, advance on execute.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_data_q <= OUT_TDATA_W'({nxt.vf, nxt.zf, nxt.b, nxt.a, PCO_W'(nxt.pc)});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`ASSERT_NEXT(a_exec_shows, clk, arst_n, exec, m_tvalid, "executed instruction gave no result")
	`ASSERT_NOW(a_ready_drained, clk, arst_n, !m_tvalid, s_tready, "input stalled with empty result register")
	`ASSERT_NEXT(a_hold_pending, clk, arst_n, valid_s1 && !exec, valid_s1, "pending instruction lost")

endmodule

// File: rtl/tra_store.sv
// ----------------------------------------------------------------------------
// tra_store
// Data store words with per-word valid bits; an unwritten word reads zero.
// ----------------------------------------------------------------------------
module tra_store import tra_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  store_wr_t         wr,
	input  logic [IDX_W-1:0]  rd_idx,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0]      mem_q [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.idx] <= wr.data;
		end
	end

	assign rd_data = vld_q[rd_idx] ? mem_q[rd_idx] : '0;

endmodule

// File: rtl/tra_core.sv
// ----------------------------------------------------------------------------
// tra_core
// Architectural registers and the combinational instruction execute logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tra_core import tra_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              exec,
	input  instr_t            instr,
	input  logic [WORD_W-1:0] rd_data,
	output logic [IDX_W-1:0]  rd_idx,
	output store_wr_t         wr,
	output arch_t             nxt
);

	arch_t              state_q;
	logic [PC_BITS-1:0] pc_inc;
	logic [PC_BITS-1:0] target;
	logic [WORD_W-1:0]  sum;
	logic               add_ovf;

	assign rd_idx  = word_index(instr.mem_address);
	assign pc_inc  = state_q.pc + PC_BITS'(1);
	assign target  = PC_BITS'(instr.jump_target);
	assign sum     = state_q.a + state_q.b;
	assign add_ovf = ((state_q.a[WORD_W-1] ^ sum[WORD_W-1])
		& (state_q.b[WORD_W-1] ^ sum[WORD_W-1]));

	always_comb begin
		nxt     = state_q;
		wr.en   = 1'b0;
		wr.idx  = rd_idx;
		wr.data = '0;
		case (instr.action)
			OP_DEC: begin
				wr.en  = 1'b1;
				nxt.pc = pc_inc;
			end
			OP_LDA: begin
				nxt.a  = rd_data;
				nxt.pc = pc_inc;
			end
			OP_LDB: begin
				nxt.b  = rd_data;
				nxt.pc = pc_inc;
			end
			OP_LDI: begin
				nxt.a  = instr.immediate;
				nxt.pc = pc_inc;
			end
			OP_ST: begin
				wr.en   = 1'b1;
				wr.data = state_q.a;
				nxt.pc  = pc_inc;
			end
			OP_XCH: begin
				nxt.a  = state_q.b;
				nxt.b  = state_q.a;
				nxt.pc = pc_inc;
			end
			OP_JMP: begin
				nxt.pc = target;
			end
			OP_JZS: begin
				nxt.pc = state_q.zf ? target : pc_inc;
			end
			OP_JVS: begin
				nxt.pc = state_q.vf ? target : pc_inc;
			end
			OP_ADD: begin
				if (add_ovf) begin
					nxt.vf = 1'b1;
				end else begin
					nxt.a = sum;
					if (sum == '0) begin
						nxt.zf = 1'b1;
					end
				end
				nxt.pc = pc_inc;
			end
			OP_HLT: begin
				nxt.pc = pc_inc;
			end
			default: begin
			end
		endcase
		wr.en = wr.en & exec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (exec) begin
			state_q <= nxt;
		end
	end

	`ASSERT_NEXT(a_zf_sticky, clk, arst_n, state_q.zf, state_q.zf, "zero flag dropped")
	`ASSERT_NEXT(a_vf_sticky, clk, arst_n, state_q.vf, state_q.vf, "overflow flag dropped")
	`ASSERT_NEXT(a_bad_op_pc, clk, arst_n, exec && (instr.action > OP_HLT), $stable(state_q.pc), "unused opcode moved the PC")

endmodule

// File: tb/two_register_accumulator_cpu_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_register_accumulator_cpu_test
// Streams decoded instructions into the accumulator machine and checks
// every reported state against typed rows or a model of A, B, PC, flags, store.
// ----------------------------------------------------------------------------
module two_register_accumulator_cpu_test import tra_pkg::*;;

	// Opcodes past HLT do nothing; the result still reports the state.
	localparam logic [ACT_W-1:0] OP_UNUSED_LO = OP_HLT + 1'b1;
	localparam logic [ACT_W-1:0] OP_UNUSED_HI = {ACT_W{1'b1}};

	localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic [WORD_W-1:0] WORD_ONES = {WORD_W{1'b1}};

	localparam int RAND_ITEMS   = 1550;
	localparam int IDLE_PCT     = 22;
	localparam int QUIET_LO     = 700;   // window of transactions with no idling
	localparam int QUIET_HI     = 1000;
	localparam int HOLD_AT      = 300;   // result count that starts the long hold-off
	localparam int HOLD_CYCLES  = 120;
	localparam int DRAIN_CYCLES = 8;     // extra wait for stray results once nothing is owed
	localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on either side

	// Machine state as the result channel reports it.
	typedef struct packed {
		logic [PCO_W-1:0]  pc;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic              z;
		logic              v;
	} cpu_view_t;

	// One directed instruction, with the state typed in where it is obvious.
	typedef struct packed {
		instr_t    ins;
		logic      known;
		cpu_view_t want;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// action, mem_address, immediate, jump_target
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	// pc_out, acc_a, acc_b, zero_bit, ovf_bit, zero padding
	logic [OUT_TDATA_W-1:0] m_tdata;

	two_register_accumulator_cpu dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Model state of the machine, advanced once per accepted instruction.
	logic [WORD_W-1:0]  mdl_a;
	logic [WORD_W-1:0]  mdl_b;
	logic [PC_BITS-1:0] mdl_pc;
	logic               mdl_z;
	logic               mdl_v;
	logic [WORD_W-1:0]  mdl_store [STORE_DEPTH];

	cpu_view_t state_after_q [$];   // states still owed by the result channel
	dir_row_t  dir_tab [$];
	int        mismatches;
	int        results_seen;

	// ------------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------------
	// Model: execute one instruction, return the state after it
	// ------------------------------------------------------------------------
	function automatic cpu_view_t execute_instr(input instr_t ins);
		logic [PC_BITS-1:0] pc_next;
		logic [PC_BITS-1:0] target;
		logic [WORD_W-1:0]  sum;
		logic [WORD_W-1:0]  swap;
		int                 word;
		cpu_view_t          view;
		pc_next = mdl_pc + 1'b1;
		target  = PC_BITS'(ins.jump_target);
		word    = int'(ins.mem_address) % STORE_DEPTH;
		case (ins.action)
			OP_DEC: begin
				mdl_store[word] = '0;
				mdl_pc = pc_next;
			end
			OP_LDA: begin
				mdl_a  = mdl_store[word];
				mdl_pc = pc_next;
			end
			OP_LDB: begin
				mdl_b  = mdl_store[word];
				mdl_pc = pc_next;
			end
			OP_LDI: begin
				mdl_a  = ins.immediate;
				mdl_pc = pc_next;
			end
			OP_ST: begin
				mdl_store[word] = mdl_a;
				mdl_pc = pc_next;
			end
			OP_XCH: begin
				swap   = mdl_a;
				mdl_a  = mdl_b;
				mdl_b  = swap;
				mdl_pc = pc_next;
			end
			OP_JMP: mdl_pc = target;
			OP_JZS: mdl_pc = mdl_z ? target : pc_next;
			OP_JVS: mdl_pc = mdl_v ? target : pc_next;
			OP_ADD: begin
				sum = mdl_a + mdl_b;
				// Signed overflow: operands agree in sign and the sum does not.
				if (mdl_a[WORD_W-1] == mdl_b[WORD_W-1] && sum[WORD_W-1] != mdl_a[WORD_W-1]) begin
					mdl_v = 1'b1;
				end else begin
					mdl_a = sum;
					if (sum == '0) begin
						mdl_z = 1'b1;
					end
				end
				mdl_pc = pc_next;
			end
			OP_HLT: mdl_pc = pc_next;
			default: ;  // unused opcode: hold everything, PC included
		endcase
		view.pc = PCO_W'(mdl_pc);
		view.a  = mdl_a;
		view.b  = mdl_b;
		view.z  = mdl_z;
		view.v  = mdl_v;
		return view;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic dir_row_t dir_row(input logic [ACT_W-1:0] op,
			input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] imm,
			input logic [TGT_W-1:0] tgt, input logic known,
			input logic [PCO_W-1:0] pc, input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input logic z, input logic v);
		dir_row_t r;
		r.ins.action      = op;
		r.ins.mem_address = addr;
		r.ins.immediate   = imm;
		r.ins.jump_target = tgt;
		r.known   = known;
		r.want.pc = pc;
		r.want.a  = a;
		r.want.b  = b;
		r.want.z  = z;
		r.want.v  = v;
		return r;
	endfunction

	// Append one row to the directed table.
	function void add_row(input dir_row_t r);
		dir_tab = {dir_tab, r};
	endfunction

	function automatic instr_t rand_instr();
		instr_t ins;
		// Mostly real opcodes, a tenth of unused ones.
		if ($urandom_range(0, 99) < 10) begin
			ins.action = ACT_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		end else begin
			ins.action = ACT_W'($urandom_range(OP_DEC, OP_HLT));
		end
		ins.mem_address = ADDR_W'($urandom_range(0, ADDR_SPAN - 1));
		ins.jump_target = TGT_W'($urandom_range(0, (1 << TGT_W) - 1));
		// Small values make zero sums likely, extremes make overflow likely.
		case ($urandom_range(0, 9))
			0, 1: ins.immediate = WORD_W'($urandom_range(0, 16)) - WORD_W'(8);
			2: begin
				case ($urandom_range(0, 3))
					0: ins.immediate = WORD_MAX;
					1: ins.immediate = WORD_MIN;
					2: ins.immediate = WORD_ONES;
					default: ins.immediate = '0;
				endcase
			end
			default: ins.immediate = $urandom;
		endcase
		return ins;
	endfunction

	// Offer one instruction, hold it until the transaction, then predict.
	task automatic send_instr(input instr_t ins, input logic known,
			input cpu_view_t want, input int idx);
		cpu_view_t view;
		logic      quiet;
		quiet = (idx >= QUIET_LO && idx < QUIET_HI);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'(ins);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		view = execute_instr(ins);
		state_after_q = {state_after_q, (known ? want : view)};
	endtask

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		$display("mismatch %0s at result %0d: got %h want %h",
			what, results_seen, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------------------
	// Instruction side: directed table, then random stream, then drain
	// ------------------------------------------------------------------------
	initial begin : instr_side
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		mdl_a  = '0;
		mdl_b  = '0;
		mdl_pc = '0;
		mdl_z  = 1'b0;
		mdl_v  = 1'b0;
		foreach (mdl_store[i]) mdl_store[i] = '0;
		mismatches = 0;

		// Typed rows start from reset: all zero, store cleared.
		add_row(dir_row(OP_HLT, 0, 0, 0, 1, 1, 0, 0, 0, 0));
		add_row(dir_row(OP_LDA, 15, 0, 0, 1, 2, 0, 0, 0, 0));
		add_row(dir_row(OP_LDI, 0, WORD_MAX, 0, 1, 3, WORD_MAX, 0, 0, 0));
		add_row(dir_row(OP_XCH, 0, 0, 0, 1, 4, 0, WORD_MAX, 0, 0));
		add_row(dir_row(OP_LDI, 0, 1, 0, 1, 5, 1, WORD_MAX, 0, 0));
		// Positive overflow: A holds, overflow flag sets.
		add_row(dir_row(OP_ADD, 0, 0, 0, 1, 6, 1, WORD_MAX, 0, 1));
		add_row(dir_row(OP_JVS, 0, 0, 8'hFF, 1, 8'hFF, 1, WORD_MAX, 0, 1));
		// PC wraps past the top.
		add_row(dir_row(OP_HLT, 0, 0, 0, 1, 0, 1, WORD_MAX, 0, 1));
		add_row(dir_row(OP_UNUSED_HI, 15, WORD_ONES, 8'hFF, 1, 0, 1, WORD_MAX, 0, 1));
		// From here the model supplies the state.
		add_row(dir_row(OP_ST, 15, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(dir_row(OP_LDI, 0, WORD_MIN, 0, 0, 0, 0, 0, 0, 0));
		add_row(dir_row(OP_ST, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(dir_row(OP_LDB, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(dir_row(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(dir_row(OP_LDA, 15, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(dir_row(OP_JZS, 0, 0, 8'h55, 0, 0, 0, 0, 0, 0));
		add_row(dir_row(OP_LDI, 0, WORD_ONES, 0, 0, 0, 0, 0, 0, 0));
		add_row(dir_row(OP_LDB, 15, 0, 0, 0, 0, 0, 0, 0, 0));
		// -1 + 1: zero sum sets the zero flag, then JZS is taken.
		add_row(dir_row(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(dir_row(OP_JZS, 0, 0, 8'hAA, 0, 0, 0, 0, 0, 0));
		add_row(dir_row(OP_DEC, 15, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(dir_row(OP_LDA, 15, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(dir_row(OP_UNUSED_LO, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(dir_row(OP_JMP, 15, WORD_ONES, 8'h00, 0, 0, 0, 0, 0, 0));
		add_row(dir_row(OP_JMP, 0, 0, 8'hFF, 0, 0, 0, 0, 0, 0));

		@(posedge arst_n);
		foreach (dir_tab[i]) begin
			send_instr(dir_tab[i].ins, dir_tab[i].known, dir_tab[i].want, 0);
		end
		for (int n = 0; n < RAND_ITEMS; n++) begin
			send_instr(rand_instr(), 1'b0, '0, n);
		end
		s_tvalid <= 1'b0;

		// Drain: wait for every owed state, then a few cycles for strays.
		while (state_after_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result side: check each transaction, idle at random, one long hold-off
	// ------------------------------------------------------------------------
	initial begin : result_side
		cpu_view_t got;
		cpu_view_t want;
		int        hold_left;
		logic      hold_done;
		m_tready <= 1'b0;
		results_seen = 0;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.pc = m_tdata[7:0];
				got.a  = m_tdata[39:8];
				got.b  = m_tdata[71:40];
				got.z  = m_tdata[72];
				got.v  = m_tdata[73];
				if (state_after_q.size() == 0) begin
					report_mismatch("result with nothing expected", got.a, '0);
				end else begin
					want = state_after_q.pop_front();
					if (got.pc !== want.pc) report_mismatch("pc_out", got.pc, want.pc);
					if (got.a !== want.a) report_mismatch("acc_a", got.a, want.a);
					if (got.b !== want.b) report_mismatch("acc_b", got.b, want.b);
					if (got.z !== want.z) report_mismatch("zero_bit", got.z, want.z);
					if (got.v !== want.v) report_mismatch("ovf_bit", got.v, want.v);
				end
				results_seen++;
			end
			// Hold off long enough for the block to fill and stall its input.
			if (!hold_done && results_seen >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (results_seen >= QUIET_LO && results_seen < QUIET_HI) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run when no transaction moves for too long
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tra_pkg.sv
rtl/tra_store.sv
rtl/tra_core.sv
rtl/two_register_accumulator_cpu.sv
tb/two_register_accumulator_cpu_test.sv
